// ===== hw/rtl/scale_notification_frame_parser_macros.svh =====
// ---------------------------------------------------------------------------
// Scale notification frame parser assertion macros
// Implication checks on the parser's own logic, sampled on the rising clock.
// ---------------------------------------------------------------------------
`ifndef SCALE_NOTIFICATION_FRAME_PARSER_MACROS_SVH
`define SCALE_NOTIFICATION_FRAME_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
`define SNFP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("snfp check failed");
`define SNFP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("snfp check failed");
`else
`define SNFP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SNFP_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/snfp_pkg.sv =====
// ---------------------------------------------------------------------------
// Scale notification frame parser package
// Parse phases, frame constants and result types.
// ---------------------------------------------------------------------------
package snfp_pkg;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_GOT_EF  = 7'b0000010,
        PH_TOPIC   = 7'b0000100,
        PH_LENGTH  = 7'b0001000,
        PH_TYPE    = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_DONE    = 7'b1000000
    } phase_t;

    localparam logic [7:0] SYNC_FIRST    = 8'hEF;
    localparam logic [7:0] SYNC_SECOND   = 8'hDD;
    localparam logic [7:0] TOPIC_BATTERY = 8'h08;
    localparam logic [7:0] TOPIC_WEIGHT  = 8'h0C;
    localparam logic [7:0] TYPE_WEIGHT   = 8'h05;
    localparam logic [7:0] MIN_WEIGHT_LEN = 8'd6;
    localparam logic [7:0] BATTERY_MASK  = 8'h7F;
    localparam logic [7:0] SIGN_MASK     = 8'h02;
    localparam logic [7:0] UNIT_MIN      = 8'd1;
    localparam logic [7:0] UNIT_MAX      = 8'd4;

    localparam logic [8:0] IDX_WEIGHT_LOW  = 9'd0;
    localparam logic [8:0] IDX_WEIGHT_HIGH = 9'd1;
    localparam logic [8:0] IDX_UNIT        = 9'd4;
    localparam logic [8:0] IDX_SIGN        = 9'd5;

    localparam logic KIND_BATTERY = 1'b0;
    localparam logic KIND_WEIGHT  = 1'b1;

    typedef struct packed {
        logic        negative;
        logic [2:0]  decimals;
        logic [15:0] raw;
        logic [6:0]  battery;
    } report_t;

endpackage

// ===== hw/rtl/scale_notification_frame_parser.sv =====
// ---------------------------------------------------------------------------
// Scale notification frame parser
// Syncs on EF DD, decodes the first frame of each notification and reports
// battery level or fixed-format weight.
// ---------------------------------------------------------------------------
// Path: an input beat is held in the input register; its result is held in
//   the result register.
// Throughput: one input beat per cycle while the output is not stalled.
// Reset: aresetn low clears the parse to sync hunt and empties both registers.
`include "scale_notification_frame_parser_macros.svh"

module scale_notification_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] message_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [6:0] battery_level, [22:7] weight_raw,
                                   // [25:23] weight_decimals, [26] weight_negative
    output logic        m_tuser    // [0] frame_kind
);
    import snfp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_valid_reg, out_valid_next;
    report_t     out_report_reg;
    logic        out_kind_reg;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [8:0]  count_reg, count_next, count_inc;
    logic [7:0]  topic_reg, topic_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  wlow_reg, wlow_next;
    logic [7:0]  whigh_reg, whigh_next;
    logic [7:0]  unit_reg, unit_next;
    logic [7:0]  sign_reg, sign_next;

    logic        advance, in_fire, process, finish, hit;
    logic        hit_kind;
    report_t     hit_report;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;
    assign process  = in_valid_reg && advance;

    assign in_valid_next  = in_fire ? 1'b1 : (process ? 1'b0 : in_valid_reg);
    assign phase_cur      = in_start_reg ? PH_HUNT : phase_reg;
    assign count_inc      = count_reg + 9'd1;

    always_comb begin
        phase_next  = phase_cur;
        count_next  = count_reg;
        topic_next  = topic_reg;
        length_next = length_reg;
        type_next   = type_reg;
        wlow_next   = wlow_reg;
        whigh_next  = whigh_reg;
        unit_next   = unit_reg;
        sign_next   = sign_reg;
        finish      = 1'b0;
        case (phase_cur)
            PH_HUNT: begin
                if (in_byte_reg == SYNC_FIRST) phase_next = PH_GOT_EF;
            end
            PH_GOT_EF: begin
                if (in_byte_reg == SYNC_SECOND) begin
                    phase_next = PH_TOPIC;
                end else if (in_byte_reg != SYNC_FIRST) begin
                    phase_next = PH_HUNT;
                end
            end
            PH_TOPIC: begin
                topic_next = in_byte_reg;
                phase_next = PH_LENGTH;
            end
            PH_LENGTH: begin
                length_next = in_byte_reg;
                phase_next  = PH_TYPE;
            end
            PH_TYPE: begin
                type_next  = in_byte_reg;
                count_next = '0;
                if (length_reg == 8'd0) begin
                    finish     = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (count_reg == IDX_WEIGHT_LOW) wlow_next = in_byte_reg;
                if (count_reg == IDX_WEIGHT_HIGH) whigh_next = in_byte_reg;
                if (count_reg == IDX_UNIT) unit_next = in_byte_reg;
                if (count_reg == IDX_SIGN) sign_next = in_byte_reg;
                count_next = count_inc;
                if (count_inc >= {1'b0, length_reg}) begin
                    finish     = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
                phase_next = PH_DONE;
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_comb begin
        hit        = 1'b0;
        hit_kind   = KIND_BATTERY;
        hit_report = '0;
        if (finish && topic_next == TOPIC_BATTERY) begin
            hit                = 1'b1;
            hit_report.battery = 7'(type_next & BATTERY_MASK);
        end else if (finish && topic_next == TOPIC_WEIGHT && type_next == TYPE_WEIGHT
                     && length_next >= MIN_WEIGHT_LEN) begin
            hit             = 1'b1;
            hit_kind        = KIND_WEIGHT;
            hit_report.raw  = {whigh_next, wlow_next};
            hit_report.decimals = (unit_next >= UNIT_MIN && unit_next <= UNIT_MAX)
                                  ? unit_next[2:0] : 3'd0;
            hit_report.negative = (sign_next & SIGN_MASK) == SIGN_MASK;
        end
    end

    assign out_valid_next = (process && hit) ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            topic_reg     <= '0;
            length_reg    <= '0;
            type_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process) begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                topic_reg  <= topic_next;
                length_reg <= length_next;
                type_reg   <= type_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (process) begin
            wlow_reg  <= wlow_next;
            whigh_reg <= whigh_next;
            unit_reg  <= unit_next;
            sign_reg  <= sign_next;
        end
        if (process && hit) begin
            out_report_reg <= hit_report;
            out_kind_reg   <= hit_kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_report_reg};
    assign m_tuser  = out_kind_reg;

    `SNFP_ASSERT_IMP(a_done_silent, aclk, aresetn,
        in_valid_reg && !in_start_reg && phase_reg == PH_DONE, !hit)
    `SNFP_ASSERT_IMP(a_no_overwrite, aclk, aresetn,
        out_valid_reg && !m_tready, !process)
    `SNFP_ASSERT_IMP(a_weight_len, aclk, aresetn,
        hit && hit_kind == KIND_WEIGHT, length_next >= MIN_WEIGHT_LEN)
    `SNFP_ASSERT_NXT(a_start_hunt, aclk, aresetn,
        process && in_start_reg && in_byte_reg != SYNC_FIRST, phase_reg == PH_HUNT)

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Scale notification frame parser testbench
// Drives notification bytes over the input stream and checks every battery
// and weight report against an in-bench frame decoder or a directed row's
// expected report. A short directed table covers sync corner cases and
// field extremes; random notifications follow, with random idling on both
// streams, one long output stall and one drain pause.
// ---------------------------------------------------------------------------
module testbench;
    import snfp_pkg::*;

    typedef enum logic [1:0] {
        BY_MODEL    = 2'd0,
        WANT_NONE   = 2'd1,
        WANT_REPORT = 2'd2
    } check_mode_t;

    typedef struct packed {
        logic    kind;
        report_t rep;
    } frame_report_t;

    typedef struct packed {
        logic [7:0]    data;
        logic          start;
        check_mode_t   mode;
        frame_report_t want;
    } plan_item_t;

    localparam frame_report_t NO_REPORT = '0;
    localparam int DIRECTED_COUNT = 25;
    localparam int RANDOM_BEATS   = 1900;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] message_start
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [6:0] battery_level, [22:7] weight_raw,
                            // [25:23] weight_decimals, [26] weight_negative
    logic        m_tuser;   // [0] frame_kind

    scale_notification_frame_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    plan_item_t directed_rows [0:DIRECTED_COUNT-1] = '{
        '{8'hEF, 1'b0, BY_MODEL, NO_REPORT},
        '{8'hEF, 1'b0, BY_MODEL, NO_REPORT},
        '{8'hDD, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h08, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h00, 1'b0, BY_MODEL, NO_REPORT},
        '{8'hFF, 1'b0, WANT_REPORT, {KIND_BATTERY, 1'b0, 3'd0, 16'd0, 7'd127}},
        '{8'hEF, 1'b1, BY_MODEL, NO_REPORT},
        '{8'h41, 1'b0, BY_MODEL, NO_REPORT},
        '{8'hEF, 1'b0, BY_MODEL, NO_REPORT},
        '{8'hDD, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h0C, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h06, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h05, 1'b0, BY_MODEL, NO_REPORT},
        '{8'hFF, 1'b0, BY_MODEL, NO_REPORT},
        '{8'hFF, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h00, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h00, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h04, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h02, 1'b0, WANT_REPORT, {KIND_WEIGHT, 1'b1, 3'd4, 16'hFFFF, 7'd0}},
        '{8'hEF, 1'b1, BY_MODEL, NO_REPORT},
        '{8'hDD, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h0C, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h01, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h05, 1'b0, BY_MODEL, NO_REPORT},
        '{8'h00, 1'b0, WANT_NONE, NO_REPORT}
    };

    plan_item_t    beat_plan [$];
    frame_report_t pending_reports [$];
    int            mismatch_count = 0;
    int            reports_seen = 0;
    bit            hold_active = 1'b0;

    phase_t     sync_phase;
    logic [8:0] pay_count;
    logic [7:0] hdr_topic;
    logic [7:0] hdr_length;
    logic [7:0] hdr_type;
    logic [7:0] cap_low;
    logic [7:0] cap_high;
    logic [7:0] cap_unit;
    logic [7:0] cap_sign;
    logic       frame_closed;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic clear_decoder();
        sync_phase   = PH_HUNT;
        pay_count    = '0;
        hdr_topic    = '0;
        hdr_length   = '0;
        hdr_type     = '0;
        cap_low      = '0;
        cap_high     = '0;
        cap_unit     = '0;
        cap_sign     = '0;
        frame_closed = 1'b0;
    endtask

    task automatic close_frame(output bit got, output frame_report_t rpt);
        got          = 1'b0;
        rpt          = NO_REPORT;
        frame_closed = 1'b1;
        sync_phase   = PH_DONE;
        if (hdr_topic == TOPIC_BATTERY) begin
            got             = 1'b1;
            rpt.kind        = KIND_BATTERY;
            rpt.rep.battery = 7'(hdr_type & BATTERY_MASK);
        end else if (hdr_topic == TOPIC_WEIGHT && hdr_type == TYPE_WEIGHT &&
                     hdr_length >= MIN_WEIGHT_LEN) begin
            got              = 1'b1;
            rpt.kind         = KIND_WEIGHT;
            rpt.rep.raw      = {cap_high, cap_low};
            rpt.rep.decimals = (cap_unit >= UNIT_MIN && cap_unit <= UNIT_MAX) ?
                               cap_unit[2:0] : 3'd0;
            rpt.rep.negative = (cap_sign & SIGN_MASK) == SIGN_MASK;
        end
    endtask

    task automatic decode_beat(input logic [7:0] d, input logic st,
                               output bit got, output frame_report_t rpt);
        got = 1'b0;
        rpt = NO_REPORT;
        if (st)
            clear_decoder();
        if (!frame_closed) begin
            case (sync_phase)
                PH_HUNT: begin
                    if (d == SYNC_FIRST)
                        sync_phase = PH_GOT_EF;
                end
                PH_GOT_EF: begin
                    if (d == SYNC_SECOND)
                        sync_phase = PH_TOPIC;
                    else if (d != SYNC_FIRST)
                        sync_phase = PH_HUNT;
                end
                PH_TOPIC: begin
                    hdr_topic  = d;
                    sync_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    hdr_length = d;
                    sync_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    hdr_type  = d;
                    pay_count = '0;
                    if (hdr_length == 8'd0)
                        close_frame(got, rpt);
                    else
                        sync_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (pay_count == IDX_WEIGHT_LOW)
                        cap_low = d;
                    else if (pay_count == IDX_WEIGHT_HIGH)
                        cap_high = d;
                    else if (pay_count == IDX_UNIT)
                        cap_unit = d;
                    else if (pay_count == IDX_SIGN)
                        cap_sign = d;
                    pay_count = pay_count + 9'd1;
                    if (pay_count >= {1'b0, hdr_length})
                        close_frame(got, rpt);
                end
                default: ;
            endcase
        end
    endtask

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    task automatic add_notification();
        logic [7:0]  body [$];
        logic [7:0]  topic;
        logic [7:0]  flen;
        logic [7:0]  ftype;
        logic [7:0]  b;
        bit          zero_raw;
        int unsigned pick;
        int unsigned keep;
        plan_item_t  it;
        repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
        if ($urandom_range(0, 5) == 0)
            body.push_back(SYNC_FIRST);
        if ($urandom_range(0, 5) == 0) begin
            body.push_back(SYNC_FIRST);
            body.push_back(8'($urandom_range(0, 8'hDC)));
        end
        body.push_back(SYNC_FIRST);
        body.push_back(SYNC_SECOND);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            topic = TOPIC_BATTERY;
            flen  = 8'($urandom_range(0, 6));
            ftype = 8'($urandom);
        end else if (pick < 75) begin
            topic = TOPIC_WEIGHT;
            ftype = TYPE_WEIGHT;
            flen  = ($urandom_range(0, 49) == 0) ? 8'd255 : 8'($urandom_range(6, 12));
        end else if (pick < 85) begin
            topic = TOPIC_WEIGHT;
            ftype = TYPE_WEIGHT;
            flen  = 8'($urandom_range(0, 5));
        end else if (pick < 93) begin
            topic = 8'($urandom);
            ftype = 8'($urandom);
            flen  = 8'($urandom_range(0, 8));
        end else begin
            topic = TOPIC_WEIGHT;
            ftype = 8'($urandom);
            flen  = 8'($urandom_range(6, 10));
        end
        body.push_back(topic);
        body.push_back(flen);
        body.push_back(ftype);
        zero_raw = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < int'(flen); i++) begin
            b = 8'($urandom);
            if (i < 2 && zero_raw)
                b = 8'd0;
            else if (i == 4 && $urandom_range(0, 9) != 0)
                b = 8'($urandom_range(0, 5));
            body.push_back(b);
        end
        if ($urandom_range(0, 9) == 0 && body.size() > 1) begin
            keep = $urandom_range(1, body.size() - 1);
            body = body[0:keep-1];
        end
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
        foreach (body[i]) begin
            it       = '0;
            it.data  = body[i];
            it.start = (i == 0);
            it.mode  = BY_MODEL;
            beat_plan.push_back(it);
        end
    endtask

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic check_report();
        frame_report_t want;
        report_t       got_rep;
        got_rep = report_t'(m_tdata[26:0]);
        if (pending_reports.size() == 0) begin
            flag_mismatch("unexpected report beat", m_tdata, 0);
        end else begin
            want = pending_reports.pop_front();
            if (m_tuser !== want.kind)
                flag_mismatch("frame_kind", m_tuser, want.kind);
            if (got_rep.battery !== want.rep.battery)
                flag_mismatch("battery_level", got_rep.battery, want.rep.battery);
            if (got_rep.raw !== want.rep.raw)
                flag_mismatch("weight_raw", got_rep.raw, want.rep.raw);
            if (got_rep.decimals !== want.rep.decimals)
                flag_mismatch("weight_decimals", got_rep.decimals, want.rep.decimals);
            if (got_rep.negative !== want.rep.negative)
                flag_mismatch("weight_negative", got_rep.negative, want.rep.negative);
            if (m_tdata[31:27] !== 5'd0)
                flag_mismatch("tdata padding", m_tdata[31:27], 0);
        end
        reports_seen++;
    endtask

    initial begin : report_sink
        int rx_stall;
        int hold_left;
        bit hold_done;
        rx_stall  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                check_report();
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
                if (hold_left == 0)
                    hold_active = 1'b0;
            end else if (!hold_done && reports_seen >= 30) begin
                hold_done   = 1'b1;
                hold_left   = HOLD_CYCLES;
                hold_active = 1'b1;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else begin
                m_tready <= 1'b1;
                rx_stall = pick_gap();
            end
        end
    end

    initial begin : beat_source
        int            idx;
        int            gap_left;
        int            pause_at;
        int            pause_left;
        bit            pause_done;
        bit            all_sent;
        bit            got;
        frame_report_t rpt;
        idx        = 0;
        gap_left   = 0;
        pause_left = 8;
        pause_done = 1'b0;
        all_sent   = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tuser  <= 1'b0;
        clear_decoder();
        foreach (directed_rows[i]) beat_plan.push_back(directed_rows[i]);
        while (beat_plan.size() < DIRECTED_COUNT + RANDOM_BEATS) add_notification();
        pause_at = DIRECTED_COUNT + RANDOM_BEATS / 2;
        while (!all_sent) begin
            @(posedge aclk);
            if (s_tvalid && s_tready) begin
                decode_beat(beat_plan[idx].data, beat_plan[idx].start, got, rpt);
                case (beat_plan[idx].mode)
                    WANT_REPORT: pending_reports.push_back(beat_plan[idx].want);
                    WANT_NONE:   ;
                    default:     if (got) pending_reports.push_back(rpt);
                endcase
                idx++;
            end
            if (!s_tvalid || s_tready) begin
                if (idx == beat_plan.size()) begin
                    s_tvalid <= 1'b0;
                    all_sent = 1'b1;
                end else if (!aresetn) begin
                    s_tvalid <= 1'b0;
                end else if (idx >= pause_at && !pause_done) begin
                    s_tvalid <= 1'b0;
                    if (pending_reports.size() == 0) begin
                        if (pause_left == 0)
                            pause_done = 1'b1;
                        else
                            pause_left--;
                    end
                end else if (gap_left > 0 && !hold_active) begin
                    s_tvalid <= 1'b0;
                    gap_left--;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= beat_plan[idx].data;
                    s_tuser  <= beat_plan[idx].start;
                    gap_left = pick_gap();
                end
            end
        end
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/snfp_pkg.sv
hw/rtl/scale_notification_frame_parser.sv
test/testbench.sv
